// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the hot pixel align/subtract RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hpmas_pkg.sv =====
// Package: constants and types shared by the hot pixel align/subtract block.
`default_nettype none

package hpmas_pkg;

    localparam int PIXEL_BITS  = 16;
    localparam int MODEL_SIDE  = 7;
    localparam int MODEL_CELLS = MODEL_SIDE * MODEL_SIDE;
    localparam int WIN_SIDE    = 12;
    localparam int WIN_CELLS   = WIN_SIDE * WIN_SIDE;
    localparam int SHIFT_COUNT = 6;
    localparam int SHIFT_OFS   = 3;
    localparam int MEDIAN_BITS = 16;
    localparam int CORR_BITS   = 17;

    // 49 cells of up to 2^PIXEL_BITS-1 each
    localparam int SAD_W  = PIXEL_BITS + 6;
    localparam int CORR_W = ((PIXEL_BITS > MEDIAN_BITS) ? PIXEL_BITS : MEDIAN_BITS) + 2;

    localparam logic [1:0] OP_LOAD_MODEL = 2'd0;
    localparam logic [1:0] OP_LOAD_WIN   = 2'd1;
    localparam logic [1:0] OP_RUN        = 2'd2;

    typedef struct packed {
        logic       emit;
        logic       first_cell;
        logic       last_cell;
        logic       first_off;
        logic       last_off;
        logic [2:0] x;
        logic [2:0] y;
        logic [2:0] ox;
        logic [2:0] oy;
    } hpmas_tag_t;

    typedef struct packed {
        logic       model_we;
        logic       win_we;
        logic       rd_valid;
        hpmas_tag_t tag;
    } hpmas_cmd_t;

    typedef struct packed {
        logic score_done;
        logic out_fire;
    } hpmas_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/hpmas_ctrl.sv =====
// Controller: accepts commands, sequences offset scoring and result emission.
`default_nettype none
`include "assert_macros.svh"

module hpmas_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [1:0]              s_op,
    input  wire hpmas_pkg::hpmas_status_t status,
    output hpmas_pkg::hpmas_cmd_t        cmd
);
    import hpmas_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCORE,
        S_SCORE_WAIT,
        S_EMIT,
        S_EMIT_WAIT
    } state_t;

    localparam logic [2:0] SIDE_LAST  = 3'(MODEL_SIDE - 1);
    localparam logic [2:0] SHIFT_LAST = 3'(SHIFT_COUNT - 1);

    state_t     state_reg;
    logic [2:0] x_reg, y_reg, ox_reg, oy_reg;
    logic       rd_valid_reg;
    hpmas_tag_t tag_reg;
    logic       s_fire;
    logic       cell_last;
    logic       off_last;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cell_last = (x_reg == SIDE_LAST) && (y_reg == SIDE_LAST);
    assign off_last  = (ox_reg == SHIFT_LAST) && (oy_reg == SHIFT_LAST);

    always_comb
    begin
        cmd.model_we = s_fire && (s_op == OP_LOAD_MODEL);
        cmd.win_we   = s_fire && (s_op == OP_LOAD_WIN);
        cmd.rd_valid = rd_valid_reg;
        cmd.tag      = tag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            x_reg        <= '0;
            y_reg        <= '0;
            ox_reg       <= '0;
            oy_reg       <= '0;
            rd_valid_reg <= 1'b0;
            tag_reg      <= '0;
        end
        else
        begin
            rd_valid_reg       <= 1'b0;
            tag_reg.x          <= x_reg;
            tag_reg.y          <= y_reg;
            tag_reg.ox         <= ox_reg;
            tag_reg.oy         <= oy_reg;
            tag_reg.first_cell <= (x_reg == 3'd0) && (y_reg == 3'd0);
            tag_reg.last_cell  <= cell_last;
            tag_reg.first_off  <= (ox_reg == 3'd0) && (oy_reg == 3'd0);
            tag_reg.last_off   <= off_last;
            tag_reg.emit       <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    x_reg  <= '0;
                    y_reg  <= '0;
                    ox_reg <= '0;
                    oy_reg <= '0;
                    if (s_fire && (s_op == OP_RUN))
                        state_reg <= S_SCORE;
                end
                S_SCORE:
                begin
                    rd_valid_reg <= 1'b1;
                    // y fastest, then x, then dy, then dx
                    if (y_reg != SIDE_LAST)
                        y_reg <= y_reg + 3'd1;
                    else
                    begin
                        y_reg <= '0;
                        if (x_reg != SIDE_LAST)
                            x_reg <= x_reg + 3'd1;
                        else
                        begin
                            x_reg <= '0;
                            if (oy_reg != SHIFT_LAST)
                                oy_reg <= oy_reg + 3'd1;
                            else
                            begin
                                oy_reg <= '0;
                                ox_reg <= ox_reg + 3'd1;
                            end
                        end
                    end
                    if (cell_last && off_last)
                    begin
                        ox_reg    <= '0;
                        state_reg <= S_SCORE_WAIT;
                    end
                end
                S_SCORE_WAIT:
                begin
                    if (status.score_done)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    rd_valid_reg <= 1'b1;
                    tag_reg.emit <= 1'b1;
                    state_reg    <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT:
                begin
                    if (status.out_fire)
                    begin
                        if (cell_last)
                            state_reg <= S_IDLE;
                        else
                            state_reg <= S_EMIT;
                        if (y_reg != SIDE_LAST)
                            y_reg <= y_reg + 3'd1;
                        else
                        begin
                            y_reg <= '0;
                            x_reg <= x_reg + 3'd1;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEXT(a_score_done_when_waiting, clk, rst_n, status.score_done,
        state_reg == S_EMIT, "score done outside the scoring wait")
    `ASSERT_ALWAYS(a_out_fire_when_emitting, clk, rst_n,
        !status.out_fire || (state_reg == S_EMIT_WAIT), "result transfer outside emission")

endmodule

`default_nettype wire

// ===== rtl/core/hpmas_dp.sv =====
// Datapath: model/window stores, SAD accumulate, best offset and correction.
`default_nettype none
`include "assert_macros.svh"

module hpmas_dp (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire hpmas_pkg::hpmas_cmd_t   cmd,
    output hpmas_pkg::hpmas_status_t     status,
    input  wire logic [7:0]              load_index,
    input  wire logic [15:0]             load_value,
    input  wire logic                    cfg_we,
    input  wire logic [15:0]             cfg_wdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [31:0]                  m_tdata,
    output logic                         m_tlast
);
    import hpmas_pkg::*;

    logic [PIXEL_BITS-1:0] model_mem [MODEL_CELLS];
    logic [PIXEL_BITS-1:0] win_mem   [WIN_CELLS];

    logic [PIXEL_BITS-1:0] load_pix;
    logic [5:0]            maddr;
    logic [7:0]            waddr;
    logic [2:0]            ox_sel, oy_sel;

    logic [PIXEL_BITS-1:0] m_rd_reg, w_rd_reg;
    logic                  p1_valid_reg;
    hpmas_tag_t            p1_tag_reg;

    logic signed [PIXEL_BITS:0] diff;
    logic signed [PIXEL_BITS:0] d_reg;
    logic [PIXEL_BITS-1:0]      absd_reg;
    logic                       p2_valid_reg;
    hpmas_tag_t                 p2_tag_reg;

    logic [SAD_W-1:0] acc_reg, best_sum_reg, sum_now;
    logic [2:0]       best_ox_reg, best_oy_reg;
    logic             score_done_reg;

    logic signed [PIXEL_BITS:0] d_adj, half;
    logic signed [CORR_W-1:0]   v;
    logic [CORR_W-1:0]          v_abs;

    logic [MEDIAN_BITS-1:0] median_reg;
    logic                   m_tvalid_reg;
    logic [CORR_BITS-1:0]   corr_reg;
    logic [2:0]             col_reg, row_reg, sx_reg, sy_reg;
    logic                   last_reg;

    assign load_pix = PIXEL_BITS'(load_value);

    // emission reads at the winning offset
    assign ox_sel = cmd.tag.emit ? best_ox_reg : cmd.tag.ox;
    assign oy_sel = cmd.tag.emit ? best_oy_reg : cmd.tag.oy;
    assign maddr  = 6'(cmd.tag.x) + 6'(cmd.tag.y) * 6'(MODEL_SIDE);
    assign waddr  = (8'(cmd.tag.y) + 8'(oy_sel)) * 8'(WIN_SIDE) + 8'(cmd.tag.x) + 8'(ox_sel);

    always_ff @(posedge clk)
    begin
        if (cmd.model_we && (load_index < 8'(MODEL_CELLS)))
            model_mem[load_index[5:0]] <= load_pix;
        if (cmd.win_we && (load_index < 8'(WIN_CELLS)))
            win_mem[load_index] <= load_pix;
        if (cmd.rd_valid)
        begin
            m_rd_reg <= model_mem[maddr];
            w_rd_reg <= win_mem[waddr];
        end
    end

    assign diff = $signed({1'b0, m_rd_reg}) - $signed({1'b0, w_rd_reg});

    always_ff @(posedge clk)
    begin
        p1_tag_reg <= cmd.tag;
        p2_tag_reg <= p1_tag_reg;
        d_reg      <= diff;
        absd_reg   <= diff[PIXEL_BITS] ? PIXEL_BITS'(-diff) : diff[PIXEL_BITS-1:0];
        acc_reg    <= sum_now;
    end

    assign sum_now = (p2_tag_reg.first_cell ? '0 : acc_reg) + SAD_W'(absd_reg);

    // halve toward zero, add the median, take magnitude
    assign d_adj = d_reg + $signed({{PIXEL_BITS{1'b0}}, d_reg[PIXEL_BITS]});
    assign half  = d_adj >>> 1;
    assign v     = CORR_W'(half) + $signed(CORR_W'({1'b0, median_reg}));
    assign v_abs = v[CORR_W-1] ? CORR_W'(-v) : CORR_W'(v);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            best_sum_reg   <= '1;
            best_ox_reg    <= '0;
            best_oy_reg    <= '0;
            score_done_reg <= 1'b0;
            median_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            p1_valid_reg   <= cmd.rd_valid;
            p2_valid_reg   <= p1_valid_reg;
            score_done_reg <= 1'b0;
            if (cfg_we)
                median_reg <= cfg_wdata;
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            if (p2_valid_reg && !p2_tag_reg.emit && p2_tag_reg.last_cell)
            begin
                // first offset always taken, later ones only if strictly smaller
                if (p2_tag_reg.first_off || (sum_now < best_sum_reg))
                begin
                    best_sum_reg <= sum_now;
                    best_ox_reg  <= p2_tag_reg.ox;
                    best_oy_reg  <= p2_tag_reg.oy;
                end
                score_done_reg <= p2_tag_reg.last_off;
            end
            if (p2_valid_reg && p2_tag_reg.emit)
                m_tvalid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_valid_reg && p2_tag_reg.emit)
        begin
            corr_reg <= v_abs[CORR_BITS-1:0];
            col_reg  <= p2_tag_reg.x;
            row_reg  <= p2_tag_reg.y;
            sx_reg   <= best_ox_reg - 3'(SHIFT_OFS);
            sy_reg   <= best_oy_reg - 3'(SHIFT_OFS);
            last_reg <= p2_tag_reg.last_cell;
        end
    end

    assign m_tvalid          = m_tvalid_reg;
    assign m_tdata           = {3'b000, sy_reg, sx_reg, row_reg, col_reg, corr_reg};
    assign m_tlast           = last_reg;
    assign status.score_done = score_done_reg;
    assign status.out_fire   = m_tvalid_reg && m_tready;

    `ASSERT_ALWAYS(a_emit_into_empty_out, clk, rst_n,
        !(p2_valid_reg && p2_tag_reg.emit) || !m_tvalid_reg,
        "emission reached a full output register")
    `ASSERT_ALWAYS(a_no_score_during_output, clk, rst_n,
        !(p1_valid_reg && !p1_tag_reg.emit) || !m_tvalid_reg,
        "scoring read while a result is pending")

endmodule

`default_nettype wire

// ===== rtl/core/hot_pixel_model_align_subtract_top.sv =====
// Top level: hot pixel model alignment by SAD search and model subtraction.
//
//  Channel  | Dir | Signals                 | Contents (low bit up)
//  s_*      | in  | tvalid tready tdata tuser | tdata: index[7:0] value[23:8]; tuser: op[1:0]
//  m_*      | out | tvalid tready tdata tlast | tdata: corrected[16:0] col[19:17] row[22:20]
//           |     |                          |        shift_x[25:23] shift_y[28:26]; tlast: last
//  cfg_*    | in  | we wdata                 | image_median
//
// Loads are accepted back to back while idle. A run scores 36 offsets x 49
// cells through one model read and one window read per cycle, drains the
// pipeline and settles the winner, then emits 49 results one at a time: the
// next read starts only after the previous result has been taken.
// Input is taken only while no run is in progress; m_tready low stalls emission.
// Reset is asynchronous; the stores hold no reset value.
`default_nettype none

module hot_pixel_model_align_subtract_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // index[7:0], value[23:8]
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // corrected, col, row, shift_x, shift_y, zero pad
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);
    import hpmas_pkg::*;

    hpmas_cmd_t    cmd;
    hpmas_status_t status;

    hpmas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    hpmas_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .load_index (s_tdata[7:0]),
        .load_value (s_tdata[23:8]),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
